// File: rtl/core/tsft_pkg.sv
package tsft_pkg;

    localparam int TOPIC_SLOTS    = 16;
    localparam int SUBS_PER_TOPIC = 8;
    localparam int NAME_BYTES     = 8;

    localparam int TOPIC_W = (TOPIC_SLOTS > 1) ? $clog2(TOPIC_SLOTS) : 1;
    localparam int SUB_W   = (SUBS_PER_TOPIC > 1) ? $clog2(SUBS_PER_TOPIC) : 1;
    localparam int SUB_DEPTH = TOPIC_SLOTS * SUBS_PER_TOPIC;
    localparam int ADDR_W  = (SUB_DEPTH > 1) ? $clog2(SUB_DEPTH) : 1;

    localparam int NAME_W    = 64;
    localparam int QUEUE_W   = 8;
    localparam int PAYLOAD_W = 16;
    localparam int STATUS_W  = 2;
    localparam int REQ_W     = 2;
    localparam int S_DATA_W  = 88;
    localparam int M_DATA_W  = 32;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_REGISTER  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SUBSCRIBE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PUBLISH   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic rd;
        logic chk;
        logic ins;
    } tsft_cmd_t;

    typedef struct packed {
        logic done;
        logic rem_empty;
        logic chk_out;
        logic rem_left;
        logic last;
    } tsft_stat_t;

endpackage

// File: rtl/core/tsft_ctrl.sv
module tsft_ctrl
    import tsft_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  tsft_stat_t stat,
    output tsft_cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOOK = 6'b000010,
        S_RD   = 6'b000100,
        S_CHK  = 6'b001000,
        S_INS  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_LOOK;
            end
            S_LOOK: begin
                priority if (stat.done) state_next = S_OUT;
                else if (stat.rem_empty) state_next = S_INS;
                else state_next = S_RD;
            end
            S_RD: state_next = S_CHK;
            S_CHK: begin
                priority if (stat.chk_out) state_next = S_OUT;
                else if (stat.rem_left) state_next = S_RD;
                else state_next = S_INS;
            end
            S_INS: state_next = S_OUT;
            S_OUT: begin
                if (m_tready) state_next = stat.last ? S_IDLE : S_RD;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready    = (state_reg == S_IDLE);
    assign m_tvalid    = (state_reg == S_OUT);
    assign cmd.capture = (state_reg == S_IDLE) && s_tvalid;
    assign cmd.lookup  = (state_reg == S_LOOK);
    assign cmd.rd      = (state_reg == S_RD);
    assign cmd.chk     = (state_reg == S_CHK);
    assign cmd.ins     = (state_reg == S_INS);

endmodule

// File: rtl/core/tsft_datapath.sv
module tsft_datapath
    import tsft_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  tsft_cmd_t           cmd,
    output tsft_stat_t          stat,
    input  logic [REQ_W-1:0]    s_tuser,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                cfg_valid,
    input  logic                cfg_data,
    output logic                m_tuser,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast
);

    // latched request
    logic [REQ_W-1:0]     req_reg;
    logic [NAME_W-1:0]    key_reg;
    logic                 term_reg;
    logic [QUEUE_W-1:0]   queue_reg;
    logic [PAYLOAD_W-1:0] payload_reg;
    logic                 pool_ready_reg;

    // tables
    logic [TOPIC_SLOTS-1:0]                     topic_valid_reg;
    logic [TOPIC_SLOTS-1:0][NAME_W-1:0]         topic_key_reg;
    logic [TOPIC_SLOTS-1:0][SUBS_PER_TOPIC-1:0] sub_valid_reg;
    logic [QUEUE_W-1:0]                         sub_mem [SUB_DEPTH];

    // scan state
    logic [TOPIC_W-1:0]        t_reg;
    logic [SUBS_PER_TOPIC-1:0] rem_reg;
    logic [SUB_W-1:0]          j_reg;
    logic [QUEUE_W-1:0]        rdata_reg;

    // result register
    logic [STATUS_W-1:0]  out_status_reg;
    logic                 out_deliver_reg;
    logic [QUEUE_W-1:0]   out_queue_reg;
    logic [PAYLOAD_W-1:0] out_payload_reg;
    logic                 out_last_reg;

    // name normalization: keep bytes up to the first zero byte
    logic [NAME_W-1:0] norm_key;
    logic              norm_term;
    always_comb begin
        logic seen;
        seen      = 1'b0;
        norm_key  = '0;
        for (int i = 0; i < NAME_BYTES; i++) begin
            if (s_tdata[8*i +: 8] == 8'd0) seen = 1'b1;
            if (!seen) norm_key[8*i +: 8] = s_tdata[8*i +: 8];
        end
        norm_term = seen;
    end

    // topic match and first free topic slot
    logic               hit;
    logic               hit_ok;
    logic [TOPIC_W-1:0] hit_idx;
    logic               free_any;
    logic [TOPIC_W-1:0] free_idx;
    always_comb begin
        hit      = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int i = TOPIC_SLOTS - 1; i >= 0; i--) begin
            if (topic_valid_reg[i] && topic_key_reg[i] == key_reg) begin
                hit     = 1'b1;
                hit_idx = TOPIC_W'(i);
            end
            if (!topic_valid_reg[i]) begin
                free_any = 1'b1;
                free_idx = TOPIC_W'(i);
            end
        end
    end
    assign hit_ok = hit && (key_reg != '0) && term_reg;

    logic [SUBS_PER_TOPIC-1:0] look_mask;
    assign look_mask = sub_valid_reg[hit_idx];

    // early decision at lookup
    logic                look_done;
    logic [STATUS_W-1:0] look_status;
    logic                topic_wr;
    always_comb begin
        look_done   = 1'b1;
        look_status = ST_INVALID;
        topic_wr    = 1'b0;
        unique case (req_reg)
            REQ_REGISTER: begin
                priority if (key_reg == '0 || !term_reg) look_status = ST_INVALID;
                else if (hit_ok) look_status = ST_OK;
                else if (free_any) begin
                    look_status = ST_OK;
                    topic_wr    = 1'b1;
                end else look_status = ST_FULL;
            end
            REQ_SUBSCRIBE: begin
                priority if (queue_reg == '0) look_status = ST_INVALID;
                else if (!hit_ok) look_status = ST_NOT_FOUND;
                else look_done = 1'b0;
            end
            REQ_PUBLISH: begin
                priority if (payload_reg == '0 || !pool_ready_reg) look_status = ST_INVALID;
                else if (!hit_ok) look_status = ST_NOT_FOUND;
                else if (look_mask == '0) look_status = ST_OK;
                else look_done = 1'b0;
            end
            default: look_status = ST_INVALID;
        endcase
    end

    // lowest remaining subscriber slot
    logic [SUB_W-1:0] pick_j;
    always_comb begin
        pick_j = '0;
        for (int i = SUBS_PER_TOPIC - 1; i >= 0; i--) begin
            if (rem_reg[i]) pick_j = SUB_W'(i);
        end
    end

    logic [SUBS_PER_TOPIC-1:0] rem_clr;
    always_comb begin
        for (int i = 0; i < SUBS_PER_TOPIC; i++) begin
            rem_clr[i] = rem_reg[i] && (SUB_W'(i) != j_reg);
        end
    end

    // first free subscriber slot of the current topic
    logic [SUBS_PER_TOPIC-1:0] cur_mask;
    logic [SUB_W-1:0]          free_sub;
    logic                      sub_full;
    assign cur_mask = sub_valid_reg[t_reg];
    always_comb begin
        free_sub = '0;
        for (int i = SUBS_PER_TOPIC - 1; i >= 0; i--) begin
            if (!cur_mask[i]) free_sub = SUB_W'(i);
        end
    end
    assign sub_full = &cur_mask;

    logic [ADDR_W-1:0] base_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              mem_we;
    logic              is_pub;
    logic              match;
    assign base_addr = ADDR_W'(ADDR_W'(t_reg) * ADDR_W'(SUBS_PER_TOPIC));
    assign rd_addr   = base_addr + ADDR_W'(pick_j);
    assign wr_addr   = base_addr + ADDR_W'(free_sub);
    assign mem_we    = cmd.ins && !sub_full;
    assign is_pub    = (req_reg == REQ_PUBLISH);
    assign match     = (rdata_reg == queue_reg);

    always_ff @(posedge aclk) begin
        if (mem_we) sub_mem[wr_addr] <= queue_reg;
        if (cmd.rd) rdata_reg <= sub_mem[rd_addr];
    end

    // control registers and tables
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_ready_reg  <= 1'b0;
            topic_valid_reg <= '0;
            sub_valid_reg   <= '0;
        end else begin
            if (cfg_valid) pool_ready_reg <= cfg_data;
            if (cmd.lookup && topic_wr) topic_valid_reg[free_idx] <= 1'b1;
            if (mem_we) sub_valid_reg[t_reg][free_sub] <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg     <= s_tuser;
            key_reg     <= norm_key;
            term_reg    <= norm_term;
            queue_reg   <= s_tdata[NAME_W +: QUEUE_W];
            payload_reg <= s_tdata[NAME_W + QUEUE_W +: PAYLOAD_W];
        end
        if (cmd.lookup) begin
            t_reg   <= hit_idx;
            rem_reg <= look_mask;
            if (topic_wr) topic_key_reg[free_idx] <= key_reg;
        end
        if (cmd.rd) j_reg <= pick_j;
        if (cmd.chk) rem_reg <= rem_clr;
    end

    // result register: hold until taken
    always_ff @(posedge aclk) begin
        priority if (cmd.lookup && look_done) begin
            out_status_reg  <= look_status;
            out_deliver_reg <= 1'b0;
            out_queue_reg   <= '0;
            out_payload_reg <= '0;
            out_last_reg    <= 1'b1;
        end else if (cmd.chk && is_pub) begin
            out_status_reg  <= ST_OK;
            out_deliver_reg <= 1'b1;
            out_queue_reg   <= rdata_reg;
            out_payload_reg <= payload_reg;
            out_last_reg    <= (rem_clr == '0);
        end else if ((cmd.chk && match) || cmd.ins) begin
            out_status_reg  <= (cmd.ins && sub_full) ? ST_FULL : ST_OK;
            out_deliver_reg <= 1'b0;
            out_queue_reg   <= '0;
            out_payload_reg <= '0;
            out_last_reg    <= 1'b1;
        end else begin
            out_status_reg  <= out_status_reg;
        end
    end

    assign stat.done      = look_done;
    assign stat.rem_empty = (look_mask == '0);
    assign stat.chk_out   = is_pub || match;
    assign stat.rem_left  = (rem_clr != '0);
    assign stat.last      = out_last_reg;

    assign m_tuser = out_deliver_reg;
    assign m_tdata = {{(M_DATA_W - STATUS_W - QUEUE_W - PAYLOAD_W){1'b0}},
                      out_payload_reg, out_queue_reg, out_status_reg};
    assign m_tlast = out_last_reg;

endmodule

// File: rtl/core/topic_subscriber_fanout_table.sv
// Sequence: a request is accepted in S_IDLE and looked up in S_LOOK; register, unknown
//   request, reject and empty publish results are then shown from S_OUT; subscribe runs
//   S_RD, S_CHK per stored subscriber checked, then S_INS if none matched; publish runs
//   S_RD, S_CHK, S_OUT per delivery. One request at a time: the next is taken only in
//   S_IDLE, after the last result; the subscriber memory is read once per scan step.
// Reset (aresetn low, synchronous): clear all topic and subscriber valid bits and pool_ready.
module topic_subscriber_fanout_table
    import tsft_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    // request channel
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [REQ_W-1:0]    s_tuser,   // [1:0] req_type
    input  logic [S_DATA_W-1:0] s_tdata,   // [63:0] name_bytes, [71:64] queue_id,
                                           // [87:72] payload_handle

    // result channel
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic                m_tuser,   // [0] deliver
    output logic [M_DATA_W-1:0] m_tdata,   // [1:0] status, [9:2] dest_queue,
                                           // [25:10] payload_out, [31:26] zero
    output logic                m_tlast,   // last result of the request

    // configuration: pool_ready
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);

    tsft_cmd_t  cmd;
    tsft_stat_t stat;

    // The register write is always taken and lands at once; write it only while no
    // request is in flight.
    assign cfg_ready = 1'b1;

    // Sequencer: accept, look up the topic, scan subscriber slots, present results.
    tsft_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Tables, key compare, subscriber memory and the result register.
    tsft_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// File: verif/fanout_result_checker.sv
module fanout_result_checker
    import tsft_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [REQ_W-1:0]    s_tuser,
    input  logic [S_DATA_W-1:0] s_tdata,

    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic                m_tuser,
    input  logic [M_DATA_W-1:0] m_tdata,
    input  logic                m_tlast,

    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic                cfg_data,

    output int                  fail_count,
    output int                  pending,
    output int                  requests_seen,
    output int                  results_seen,
    output int                  deliveries_seen
);

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic                 deliver;
        logic [QUEUE_W-1:0]   dest_queue;
        logic [PAYLOAD_W-1:0] payload_out;
        logic                 last;
    } route_result_t;

    route_result_t        due_results[$];
    route_result_t        want;

    logic                 topic_used [TOPIC_SLOTS];
    logic [NAME_W-1:0]    topic_keys [TOPIC_SLOTS];
    logic                 sub_used   [SUB_DEPTH];
    logic [QUEUE_W-1:0]   sub_ids    [SUB_DEPTH];
    logic                 pool_attached;

    task automatic flag_error(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    function automatic void expect_status(input logic [STATUS_W-1:0] status);
        route_result_t r;
        r = '{status: status, deliver: 1'b0, dest_queue: '0, payload_out: '0, last: 1'b1};
        due_results.push_back(r);
    endfunction

    function automatic void route_request(input logic [REQ_W-1:0]     kind,
                                          input logic [NAME_W-1:0]    raw_name,
                                          input logic [QUEUE_W-1:0]   qid,
                                          input logic [PAYLOAD_W-1:0] handle);
        logic [NAME_W-1:0] key;
        logic              terminated;
        int                hit;
        int                base;
        int                free_slot;
        int                fanout;
        int                sent;
        logic              known;
        route_result_t     r;
        key        = '0;
        terminated = 1'b0;
        hit        = -1;
        free_slot  = -1;
        fanout     = 0;
        sent       = 0;
        known      = 1'b0;

        // cut the name at its first zero byte
        for (int i = 0; i < NAME_BYTES; i++) begin
            if (!terminated) begin
                if (raw_name[8*i +: 8] == 8'h00) terminated = 1'b1;
                else key[8*i +: 8] = raw_name[8*i +: 8];
            end
        end
        if (key != '0 && terminated) begin
            for (int t = 0; t < TOPIC_SLOTS; t++)
                if (hit < 0 && topic_used[t] && topic_keys[t] == key) hit = t;
        end

        case (kind)
            REQ_REGISTER: begin
                if (key == '0 || !terminated) expect_status(ST_INVALID);
                else if (hit >= 0) expect_status(ST_OK);
                else begin
                    for (int t = 0; t < TOPIC_SLOTS; t++)
                        if (free_slot < 0 && !topic_used[t]) free_slot = t;
                    if (free_slot < 0) expect_status(ST_FULL);
                    else begin
                        topic_used[free_slot] = 1'b1;
                        topic_keys[free_slot] = key;
                        expect_status(ST_OK);
                    end
                end
            end
            REQ_SUBSCRIBE: begin
                if (qid == '0) expect_status(ST_INVALID);
                else if (hit < 0) expect_status(ST_NOT_FOUND);
                else begin
                    base = hit * SUBS_PER_TOPIC;
                    for (int j = 0; j < SUBS_PER_TOPIC; j++) begin
                        if (sub_used[base + j]) begin
                            if (sub_ids[base + j] == qid) known = 1'b1;
                        end else if (free_slot < 0) begin
                            free_slot = j;
                        end
                    end
                    if (known) expect_status(ST_OK);
                    else if (free_slot < 0) expect_status(ST_FULL);
                    else begin
                        sub_used[base + free_slot] = 1'b1;
                        sub_ids[base + free_slot]  = qid;
                        expect_status(ST_OK);
                    end
                end
            end
            REQ_PUBLISH: begin
                if (handle == '0 || !pool_attached) expect_status(ST_INVALID);
                else if (hit < 0) expect_status(ST_NOT_FOUND);
                else begin
                    base = hit * SUBS_PER_TOPIC;
                    for (int j = 0; j < SUBS_PER_TOPIC; j++)
                        if (sub_used[base + j] && sub_ids[base + j] != '0) fanout++;
                    if (fanout == 0) expect_status(ST_OK);
                    for (int j = 0; j < SUBS_PER_TOPIC; j++) begin
                        if (sub_used[base + j] && sub_ids[base + j] != '0) begin
                            sent++;
                            r = '{status: ST_OK, deliver: 1'b1, dest_queue: sub_ids[base + j],
                                  payload_out: handle, last: (sent == fanout)};
                            due_results.push_back(r);
                        end
                    end
                end
            end
            default: expect_status(ST_INVALID);
        endcase
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int t = 0; t < TOPIC_SLOTS; t++) begin
                topic_used[t] = 1'b0;
                topic_keys[t] = '0;
            end
            for (int s = 0; s < SUB_DEPTH; s++) begin
                sub_used[s] = 1'b0;
                sub_ids[s]  = '0;
            end
            pool_attached = 1'b0;
            due_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (m_tuser === 1'b1) deliveries_seen++;
                if (due_results.size() == 0) begin
                    flag_error($sformatf("unexpected result tdata=%h tuser=%b tlast=%b",
                                         m_tdata, m_tuser, m_tlast));
                end else begin
                    want = due_results.pop_front();
                    if (m_tdata[1:0] !== want.status)
                        flag_error($sformatf("status %h, expected %h",
                                             m_tdata[1:0], want.status));
                    if (m_tuser !== want.deliver)
                        flag_error($sformatf("deliver %b, expected %b",
                                             m_tuser, want.deliver));
                    if (m_tdata[9:2] !== want.dest_queue)
                        flag_error($sformatf("dest_queue %h, expected %h",
                                             m_tdata[9:2], want.dest_queue));
                    if (m_tdata[25:10] !== want.payload_out)
                        flag_error($sformatf("payload_out %h, expected %h",
                                             m_tdata[25:10], want.payload_out));
                    if (m_tlast !== want.last)
                        flag_error($sformatf("last %b, expected %b", m_tlast, want.last));
                end
            end
            if (s_tvalid && s_tready) begin
                requests_seen++;
                route_request(s_tuser, s_tdata[63:0], s_tdata[71:64], s_tdata[87:72]);
            end
            if (cfg_valid && cfg_ready) pool_attached = cfg_data;
        end
        pending <= due_results.size();
    end

endmodule

// File: verif/topic_subscriber_fanout_table_test.sv
module topic_subscriber_fanout_table_test;
    import tsft_pkg::*;

    // the fourth request code has no name in the package; the block must reject it
    localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;

    localparam int POOL_NAMES        = 18;
    localparam int PHASE_REQUESTS    = 46;
    localparam int LONG_STALL_CYCLES = 400;
    localparam int SETTLE_CYCLES     = 40;

    // directed names: widest legal name, one-byte name, the same with bytes after
    // its terminator, a name never registered, and one with no terminator at all
    localparam logic [NAME_W-1:0] WIDE_NAME   = 64'h00FF_FFFF_FFFF_FFFF;
    localparam logic [NAME_W-1:0] SHORT_NAME  = 64'h0000_0000_0000_0001;
    localparam logic [NAME_W-1:0] NOISY_SHORT = 64'hDEAD_BEEF_CAFE_0001;
    localparam logic [NAME_W-1:0] STRAY_NAME  = 64'h0000_0000_0000_0042;
    localparam logic [NAME_W-1:0] OPEN_NAME   = 64'hFFFF_FFFF_FFFF_FFFF;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [REQ_W-1:0]    s_tuser   = '0;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic                m_tuser;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_data  = 1'b0;

    int                  fail_count;
    int                  pending;
    int                  requests_seen;
    int                  results_seen;
    int                  deliveries_seen;

    int                  send_idle_pct = 0;
    int                  stall_pct     = 0;
    logic                holding_off   = 1'b0;
    event                hold_off_start;

    logic [NAME_W-1:0]   topic_pool [POOL_NAMES];

    topic_subscriber_fanout_table dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    fanout_result_checker route_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tuser         (s_tuser),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tuser         (m_tuser),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .requests_seen   (requests_seen),
        .results_seen    (results_seen),
        .deliveries_seen (deliveries_seen)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // result side: stall at the current rate, or hold off entirely during a long stall
    always @(negedge aclk) begin
        if (holding_off) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // long receiver hold-off, counted on rising edges so the ready driver
    // sees a settled flag at the falling edge
    always begin
        @(hold_off_start);
        @(posedge aclk);
        holding_off = 1'b1;
        repeat (LONG_STALL_CYCLES) @(posedge aclk);
        holding_off = 1'b0;
    end

    initial begin
        #(4_000_000);
        $display("** topic_subscriber_fanout_table: FAILED **");
        $finish;
    end

    // random name bytes, all nonzero, packed first byte lowest
    function automatic logic [NAME_W-1:0] make_key(input int len);
        logic [NAME_W-1:0] key;
        key = '0;
        for (int i = 0; i < len; i++) key[8*i +: 8] = 8'($urandom_range(1, 255));
        return key;
    endfunction

    // sometimes fill the bytes past the terminator with noise; the name must not change
    function automatic logic [NAME_W-1:0] dress_name(input logic [NAME_W-1:0] key);
        int                len;
        logic [NAME_W-1:0] noise;
        len   = 0;
        noise = {$urandom, $urandom};
        for (int i = 0; i < 8; i++) if (key[8*i +: 8] != 8'h00) len = i + 1;
        if (len < 7 && $urandom_range(1) == 1) return key | (noise << (8 * (len + 1)));
        return key;
    endfunction

    // offer one request; hold it until accepted, leave tvalid high for the next call
    task automatic send_request(input logic [REQ_W-1:0]     kind,
                                input logic [NAME_W-1:0]    name,
                                input logic [QUEUE_W-1:0]   qid,
                                input logic [PAYLOAD_W-1:0] handle);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {handle, qid, name};
        do @(posedge aclk); while (!s_tready);
    endtask

    // drop tvalid, drain every expected result, then let the block go quiet
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_pool(input logic attached);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= attached;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // mostly well-formed traffic over a small name set so topics fill up, a hot
    // subset of names and queue ids so subscriber slots run out, some broken requests
    task automatic random_request();
        int                   pick;
        int                   slot;
        logic [REQ_W-1:0]     kind;
        logic [NAME_W-1:0]    name;
        logic [QUEUE_W-1:0]   qid;
        logic [PAYLOAD_W-1:0] handle;
        logic [QUEUE_W-1:0]   stray_qid;
        logic [PAYLOAD_W-1:0] stray_handle;
        pick         = $urandom_range(99);
        slot         = ($urandom_range(1) == 1) ? $urandom_range(3)
                                                : $urandom_range(POOL_NAMES - 1);
        name         = dress_name(topic_pool[slot]);
        qid          = ($urandom_range(1) == 1) ? 8'($urandom_range(1, 12))
                                                : 8'($urandom_range(1, 255));
        handle       = 16'($urandom_range(1, 65535));
        stray_qid    = 8'($urandom);
        stray_handle = 16'($urandom);
        if (pick < 22) begin
            send_request(REQ_REGISTER, name, stray_qid, stray_handle);
        end else if (pick < 55) begin
            send_request(REQ_SUBSCRIBE, name, qid, stray_handle);
        end else if (pick < 90) begin
            send_request(REQ_PUBLISH, name, stray_qid, handle);
        end else if (pick < 93) begin
            send_request(REQ_RESERVED, {$urandom, $urandom}, stray_qid, stray_handle);
        end else begin
            kind = 2'($urandom_range(2));
            case ($urandom_range(3))
                0: send_request(kind, 64'({$urandom, $urandom}) << 8, qid, handle);
                1: send_request(kind, make_key(8), qid, handle);
                2: send_request(REQ_SUBSCRIBE, name, '0, stray_handle);
                default: send_request(REQ_PUBLISH, name, stray_qid, '0);
            endcase
        end
    endtask

    task automatic random_phase(input int count);
        for (int n = 0; n < count; n++) random_request();
    endtask

    initial begin
        logic [QUEUE_W-1:0] fill_ids [SUBS_PER_TOPIC];
        fill_ids = '{8'hFF, 8'h01, 8'h80, 8'h7F, 8'h03, 8'h04, 8'h05, 8'h06};
        for (int i = 0; i < POOL_NAMES; i++) topic_pool[i] = make_key($urandom_range(1, 7));

        // hold reset low, then release it at a falling edge
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // pool starts detached: publish must be rejected
        send_request(REQ_REGISTER, WIDE_NAME, 8'h00, 16'h0000);
        send_request(REQ_PUBLISH, WIDE_NAME, 8'h00, 16'h0001);
        wait_idle();
        write_pool(1'b1);

        // rejects, idempotent register, lookups that miss
        send_request(REQ_RESERVED, WIDE_NAME, 8'hFF, 16'hFFFF);
        send_request(REQ_REGISTER, '0, 8'h00, 16'h0000);
        send_request(REQ_REGISTER, OPEN_NAME, 8'h00, 16'h0000);
        send_request(REQ_REGISTER, NOISY_SHORT, 8'h00, 16'h0000);
        send_request(REQ_REGISTER, SHORT_NAME, 8'h00, 16'h0000);
        send_request(REQ_SUBSCRIBE, WIDE_NAME, 8'h00, 16'h0000);
        send_request(REQ_SUBSCRIBE, STRAY_NAME, 8'h01, 16'h0000);
        send_request(REQ_SUBSCRIBE, OPEN_NAME, 8'h01, 16'h0000);
        send_request(REQ_PUBLISH, SHORT_NAME, 8'h00, 16'hFFFF);
        send_request(REQ_PUBLISH, STRAY_NAME, 8'h00, 16'h0001);
        send_request(REQ_PUBLISH, WIDE_NAME, 8'h00, 16'h0000);

        // fill every subscriber slot, repeat one queue, overflow, then fan out
        for (int j = 0; j < SUBS_PER_TOPIC; j++)
            send_request(REQ_SUBSCRIBE, WIDE_NAME, fill_ids[j], 16'h0000);
        send_request(REQ_SUBSCRIBE, WIDE_NAME, 8'h01, 16'h0000);
        send_request(REQ_SUBSCRIBE, WIDE_NAME, 8'h09, 16'h0000);
        send_request(REQ_PUBLISH, WIDE_NAME, 8'h00, 16'hFFFF);
        send_request(REQ_PUBLISH, '0, 8'h00, 16'h0001);

        // no idling at all
        random_phase(PHASE_REQUESTS);

        // receiver holds off while full fan-outs keep coming, so the block stalls its input
        -> hold_off_start;
        for (int n = 0; n < 12; n++)
            send_request(REQ_PUBLISH, dress_name(WIDE_NAME), 8'($urandom),
                         16'($urandom_range(1, 65535)));

        // sparse sender
        send_idle_pct = 85;
        random_phase(PHASE_REQUESTS);

        // a short stretch with the pool detached again
        wait_idle();
        write_pool(1'b0);
        send_idle_pct = 0;
        random_phase(8);
        wait_idle();
        write_pool(1'b1);

        // slow receiver
        stall_pct = 85;
        random_phase(PHASE_REQUESTS);

        // light idling on both sides
        send_idle_pct = 6;
        stall_pct     = 6;
        random_phase(PHASE_REQUESTS);

        wait_idle();

        $display("Covered %0d requests and %0d results (%0d deliveries) with the pool",
                 requests_seen, results_seen, deliveries_seen);
        $display("on and off, full tables, four idle mixes and a %0d-cycle receiver hold-off.",
                 LONG_STALL_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("** topic_subscriber_fanout_table: PASSED **");
        end else begin
            $display("** topic_subscriber_fanout_table: FAILED **");
        end
        $finish;
    end

endmodule
